// ===== rtl/core/rws_pkg.sv =====
package rws_pkg;

  localparam int POP_MAX_DEF    = 16;
  localparam int SCORE_BITS_DEF = 16;

  localparam int CMD_W      = 1;
  localparam int SLOT_W     = 4;
  localparam int SCORE_W    = 16;
  localparam int CHANCE_W   = 7;
  localparam int IDX_W      = 4;
  localparam int POP_CNT_W  = 5;
  localparam int APB_DATA_W = 32;
  localparam int APB_ADDR_W = 2;

  localparam logic [CMD_W-1:0]      CMD_LOAD   = 1'b0;
  localparam logic [CMD_W-1:0]      CMD_SELECT = 1'b1;
  localparam logic [APB_ADDR_W-1:0] REG_POP_COUNT = 2'd0;
  localparam logic [POP_CNT_W-1:0]  POP_COUNT_RST = 5'd16;
  localparam logic [CHANCE_W-1:0]   PCT_SCALE     = 7'd100;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SUM,
    S_SCAN
  } seq_state_t;

  typedef struct packed {
    logic clear;
    logic add;
    logic scan;
  } mac_ctl_t;

endpackage

// ===== rtl/core/roulette_wheel_selector_core.sv =====
// Fitness-proportionate parent selection.
// Config: APB port, register pop_count at byte address 0 (reset 16), active
//   slots 0..pop_count-1, saturated to POP_MAX. Write only while idle.
// Input: a transaction is taken when start is high and busy is low.
//   Load (in_cmd=0): writes in_score into slot in_slot, no result, busy stays
//   low so loads may come every cycle while idle. Slots past POP_MAX ignored.
//   Select (in_cmd=1): pass one accumulates in_chance*score over the active
//   slots, pass two accumulates 100*score and stops at the first slot whose
//   running sum exceeds the first total.
// Busy: a select holds busy through both passes over its n active slots; the
//   result strobe follows in the first cycle with busy low, where the next
//   transaction may already be taken. One store entry is read per cycle
//   through the single RAM read port, feeding one shared multiply-accumulate
//   unit.
// Result: out_valid pulses one cycle with out_parent_index and out_found;
//   there is no backpressure, the receiver must take it then.
// Reset: store entries read as zero until loaded, pop_count returns to 16,
//   the sequencer goes idle. No clearing pass is needed.
module roulette_wheel_selector_core #(
  parameter int POP_MAX    = rws_pkg::POP_MAX_DEF,
  parameter int SCORE_BITS = rws_pkg::SCORE_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  output logic                             busy,
  input  logic [rws_pkg::CMD_W-1:0]        in_cmd,
  input  logic [rws_pkg::SLOT_W-1:0]       in_slot,
  input  logic [rws_pkg::SCORE_W-1:0]      in_score,
  input  logic [rws_pkg::CHANCE_W-1:0]     in_chance,
  output logic                             out_valid,
  output logic [rws_pkg::IDX_W-1:0]        out_parent_index,
  output logic                             out_found,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [rws_pkg::APB_ADDR_W-1:0]   paddr,
  input  logic [rws_pkg::APB_DATA_W-1:0]   pwdata,
  output logic [rws_pkg::APB_DATA_W-1:0]   prdata,
  output logic                             pready
);
  import rws_pkg::*;

  localparam int AW    = $clog2(POP_MAX);
  localparam int ACC_W = SCORE_BITS + AW + CHANCE_W;
  localparam int SLW   = SLOT_W + AW;

  logic [POP_CNT_W-1:0] cfg_pop_count_r, cfg_pop_count_nxt;
  logic [POP_MAX-1:0]   valid_r, valid_nxt;
  logic                 vld_q_r, vld_q_nxt;

  logic                          take, start_sel, load_we, cfg_we;
  logic [SLW-1:0]                slot_w;
  logic [SCORE_W+SCORE_BITS-1:0] score_w;
  logic                          rd_en;
  logic [AW-1:0]                 rd_addr;
  logic [SCORE_BITS-1:0]         ram_q, rd_data;
  logic [ACC_W-1:0]              acc;
  logic [CHANCE_W-1:0]           chance_q;
  mac_ctl_t                      mac_ctl;

  assign take      = start && !busy;
  assign start_sel = take && (in_cmd == CMD_SELECT);
  assign slot_w    = SLW'(in_slot);
  assign score_w   = (SCORE_W + SCORE_BITS)'(in_score);
  assign load_we   = take && (in_cmd == CMD_LOAD) && (slot_w < SLW'(POP_MAX));

  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && pready && (paddr == REG_POP_COUNT);
  assign prdata = (paddr == REG_POP_COUNT) ? APB_DATA_W'(cfg_pop_count_r) : '0;

  always_comb begin
    cfg_pop_count_nxt = cfg_we ? pwdata[POP_CNT_W-1:0] : cfg_pop_count_r;
    valid_nxt         = valid_r;
    if (load_we) begin
      valid_nxt[slot_w[AW-1:0]] = 1'b1;
    end
    vld_q_nxt = rd_en ? valid_r[rd_addr] : vld_q_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_pop_count_r <= POP_COUNT_RST;
      valid_r         <= '0;
      vld_q_r         <= 1'b0;
    end else begin
      cfg_pop_count_r <= cfg_pop_count_nxt;
      valid_r         <= valid_nxt;
      vld_q_r         <= vld_q_nxt;
    end
  end

  assign rd_data = vld_q_r ? ram_q : '0;

  rws_ram #(
    .WIDTH (SCORE_BITS),
    .DEPTH (POP_MAX)
  ) u_store (
    .clk   (clk),
    .we    (load_we),
    .waddr (slot_w[AW-1:0]),
    .wdata (score_w[SCORE_BITS-1:0]),
    .re    (rd_en),
    .raddr (rd_addr),
    .rdata (ram_q)
  );

  rws_mac #(
    .POP_MAX    (POP_MAX),
    .SCORE_BITS (SCORE_BITS)
  ) u_mac (
    .clk    (clk),
    .ctl    (mac_ctl),
    .chance (chance_q),
    .data   (rd_data),
    .acc    (acc)
  );

  rws_seq #(
    .POP_MAX    (POP_MAX),
    .SCORE_BITS (SCORE_BITS)
  ) u_seq (
    .clk              (clk),
    .rst_n            (rst_n),
    .start_sel        (start_sel),
    .chance           (in_chance),
    .pop_count        (cfg_pop_count_r),
    .acc              (acc),
    .busy             (busy),
    .rd_en            (rd_en),
    .rd_addr          (rd_addr),
    .mac_ctl          (mac_ctl),
    .chance_q         (chance_q),
    .out_valid        (out_valid),
    .out_parent_index (out_parent_index),
    .out_found        (out_found)
  );

endmodule

// ===== rtl/core/rws_ram.sv =====
module rws_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/core/rws_mac.sv =====
module rws_mac #(
  parameter int POP_MAX    = rws_pkg::POP_MAX_DEF,
  parameter int SCORE_BITS = rws_pkg::SCORE_BITS_DEF
) (
  input  logic                                                            clk,
  input  rws_pkg::mac_ctl_t                                               ctl,
  input  logic [rws_pkg::CHANCE_W-1:0]                                    chance,
  input  logic [SCORE_BITS-1:0]                                           data,
  output logic [SCORE_BITS+$clog2(POP_MAX)+rws_pkg::CHANCE_W-1:0]         acc
);
  import rws_pkg::*;

  localparam int ACC_W  = SCORE_BITS + $clog2(POP_MAX) + CHANCE_W;
  localparam int PROD_W = SCORE_BITS + CHANCE_W;

  logic [ACC_W-1:0]    acc_r, acc_nxt;
  logic [CHANCE_W-1:0] factor;
  logic [PROD_W-1:0]   prod;

  assign factor = ctl.scan ? PCT_SCALE : chance;
  assign prod   = PROD_W'(factor) * PROD_W'(data);

  always_comb begin
    acc_nxt = acc_r;
    if (ctl.clear) begin
      acc_nxt = '0;
    end else if (ctl.add) begin
      acc_nxt = acc_r + ACC_W'(prod);
    end
  end

  always_ff @(posedge clk) begin
    acc_r <= acc_nxt;
  end

  assign acc = acc_r;

endmodule

// ===== rtl/core/rws_seq.sv =====
module rws_seq #(
  parameter int POP_MAX    = rws_pkg::POP_MAX_DEF,
  parameter int SCORE_BITS = rws_pkg::SCORE_BITS_DEF
) (
  input  logic                                                    clk,
  input  logic                                                    rst_n,
  input  logic                                                    start_sel,
  input  logic [rws_pkg::CHANCE_W-1:0]                            chance,
  input  logic [rws_pkg::POP_CNT_W-1:0]                           pop_count,
  input  logic [SCORE_BITS+$clog2(POP_MAX)+rws_pkg::CHANCE_W-1:0] acc,
  output logic                                                    busy,
  output logic                                                    rd_en,
  output logic [$clog2(POP_MAX)-1:0]                              rd_addr,
  output rws_pkg::mac_ctl_t                                       mac_ctl,
  output logic [rws_pkg::CHANCE_W-1:0]                            chance_q,
  output logic                                                    out_valid,
  output logic [rws_pkg::IDX_W-1:0]                               out_parent_index,
  output logic                                                    out_found
);
  import rws_pkg::*;

  localparam int AW    = $clog2(POP_MAX);
  localparam int N_W   = $clog2(POP_MAX + 1);
  localparam int CW    = N_W + POP_CNT_W;
  localparam int ACC_W = SCORE_BITS + AW + CHANCE_W;

  seq_state_t state_r, state_nxt;

  logic [N_W-1:0]      issue_cnt_r, issue_cnt_nxt;
  logic [N_W-1:0]      n_r, n_nxt;
  logic [CHANCE_W-1:0] chance_r, chance_nxt;
  logic                rd_pend_r, rd_pend_nxt;
  logic [AW-1:0]       rd_idx_r, rd_idx_nxt;
  logic                cmp_pend_r, cmp_pend_nxt;
  logic [AW-1:0]       cmp_idx_r, cmp_idx_nxt;
  logic [ACC_W-1:0]    lhs_r, lhs_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [IDX_W-1:0]    out_idx_r, out_idx_nxt;
  logic                out_found_r, out_found_nxt;

  logic [CW-1:0]       pc_w, n_w;
  logic [N_W-1:0]      n_act;
  logic [AW+IDX_W-1:0] idx_w;
  logic                issue_more, hit, scan_done, sum_done, finish, issue;

  assign pc_w  = CW'(pop_count);
  assign n_w   = (pc_w > CW'(POP_MAX)) ? CW'(POP_MAX) : pc_w;
  assign n_act = n_w[N_W-1:0];
  assign idx_w = (AW + IDX_W)'(cmp_idx_r);

  assign issue_more = issue_cnt_r < n_r;
  assign hit        = (state_r == S_SCAN) && cmp_pend_r && (lhs_r < acc);
  assign scan_done  = (state_r == S_SCAN) && !issue_more && !rd_pend_r && !cmp_pend_r;
  assign sum_done   = (state_r == S_SUM) && !issue_more && !rd_pend_r;
  assign finish     = hit || scan_done;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (start_sel) state_nxt = S_SUM;
      end
      S_SUM: begin
        if (sum_done) state_nxt = S_SCAN;
      end
      S_SCAN: begin
        if (finish) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    issue         = 1'b0;
    mac_ctl       = '0;
    unique case (state_r)
      S_IDLE: begin
        mac_ctl.clear = start_sel;
      end
      S_SUM: begin
        issue         = issue_more;
        mac_ctl.clear = sum_done;
        mac_ctl.add   = rd_pend_r;
      end
      S_SCAN: begin
        issue        = issue_more && !finish;
        mac_ctl.add  = rd_pend_r;
        mac_ctl.scan = 1'b1;
      end
      default: begin
        issue = 1'b0;
      end
    endcase
  end

  always_comb begin
    issue_cnt_nxt = issue_cnt_r;
    if ((state_r == S_IDLE && start_sel) || sum_done) begin
      issue_cnt_nxt = '0;
    end else if (issue) begin
      issue_cnt_nxt = issue_cnt_r + N_W'(1);
    end
    n_nxt         = (state_r == S_IDLE && start_sel) ? n_act : n_r;
    chance_nxt    = (state_r == S_IDLE && start_sel) ? chance : chance_r;
    rd_pend_nxt   = issue;
    rd_idx_nxt    = issue_cnt_r[AW-1:0];
    cmp_pend_nxt  = rd_pend_r && (state_r == S_SCAN) && !finish;
    cmp_idx_nxt   = rd_idx_r;
    lhs_nxt       = sum_done ? acc : lhs_r;
    out_valid_nxt = finish;
    out_idx_nxt   = hit ? idx_w[IDX_W-1:0] : '0;
    out_found_nxt = hit;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      issue_cnt_r <= '0;
      rd_pend_r   <= 1'b0;
      cmp_pend_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      issue_cnt_r <= issue_cnt_nxt;
      rd_pend_r   <= rd_pend_nxt;
      cmp_pend_r  <= cmp_pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    n_r         <= n_nxt;
    chance_r    <= chance_nxt;
    rd_idx_r    <= rd_idx_nxt;
    cmp_idx_r   <= cmp_idx_nxt;
    lhs_r       <= lhs_nxt;
    out_idx_r   <= out_idx_nxt;
    out_found_r <= out_found_nxt;
  end

  assign busy             = (state_r != S_IDLE);
  assign rd_en            = issue;
  assign rd_addr          = issue_cnt_r[AW-1:0];
  assign chance_q         = chance_r;
  assign out_valid        = out_valid_r;
  assign out_parent_index = out_idx_r;
  assign out_found        = out_found_r;

  a_out_ends_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy && $past(busy))
    else $error("result strobe without a finished select");

  a_miss_index_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_found |-> out_parent_index == '0)
    else $error("miss result carries nonzero index");

  a_issue_bound: assert property (@(posedge clk) disable iff (!rst_n)
    busy |-> issue_cnt_r <= n_r)
    else $error("read issue count ran past active count");

  a_busy_from_start: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(busy) |-> $past(start_sel))
    else $error("busy without an accepted select");

endmodule
